@@ rtl/tcw_pkg.sv @@
// tcw_pkg: shared types, codes and constants of the text console writer
// no dependencies; imported by tcw_seq and text_console_writer
`default_nettype none

package tcw_pkg;

  localparam int DEF_COLS = 80;
  localparam int DEF_ROWS = 25;

  localparam int ACTION_W = 2;
  localparam int CHAR_W   = 8;
  localparam int ATTR_W   = 8;
  localparam int INDEX_W  = 11;
  localparam int OCOL_W   = 7;
  localparam int OROW_W   = 5;
  localparam int CELL_W   = CHAR_W + ATTR_W;

  localparam logic [CHAR_W-1:0] CHAR_BLANK = 8'h20;
  localparam logic [CHAR_W-1:0] CHAR_NL    = 8'h0A;
  localparam logic [CHAR_W-1:0] CHAR_BS    = 8'h08;
  localparam logic [ATTR_W-1:0] RESET_ATTR = 8'h0F;

  typedef enum logic [ACTION_W-1:0] {
    ACT_PUT      = 2'd0,
    ACT_PUT_ATTR = 2'd1,
    ACT_CLEAR    = 2'd2,
    ACT_READ     = 2'd3
  } action_t;

  // finished result handed from the sequencer to the output register
  typedef struct packed {
    logic [OCOL_W-1:0] cursor_col;
    logic [OROW_W-1:0] cursor_row;
    logic              scrolled;
    logic [CELL_W-1:0] cell_value;
  } res_t;

  function automatic logic [CELL_W-1:0] make_cell(input logic [CHAR_W-1:0] ch,
                                                  input logic [ATTR_W-1:0] at);
    return {at, ch};
  endfunction

endpackage

`default_nettype wire

@@ rtl/text_console_writer.sv @@
// text_console_writer: top level, attribute register, output register,
// screen ram; uses tcw_pkg, tcw_ram and tcw_seq
//
//   channel  direction  signals                                      per transfer
//   in       sink       in_valid/in_ready, action, char, attr, index  one item
//   out      source     out_valid/out_ready, cursor, scrolled, cell   one result
//   cfg      sink       cfg_valid/cfg_ready, cfg_data                 text_attr write
//
// a put goes from idle to done unless it scrolls; a read of a cell on the screen passes a read state first
// a scroll copies the screen one cell a cycle from a single-port-pair ram and
// refills the bottom row
// a clear writes every cell once
// after reset a clearing pass over every cell runs with in_ready low
// a finished result sits in the output register while the next item is taken
`default_nettype none

module text_console_writer import tcw_pkg::*; #(
  parameter int COLS = DEF_COLS,
  parameter int ROWS = DEF_ROWS
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire logic [ACTION_W-1:0] in_action,
  input  wire logic [CHAR_W-1:0]   in_char_code,
  input  wire logic [ATTR_W-1:0]   in_attr,
  input  wire logic [INDEX_W-1:0]  in_cell_index,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output logic [OCOL_W-1:0]        out_cursor_col,
  output logic [OROW_W-1:0]        out_cursor_row,
  output logic                     out_scrolled,
  output logic [CELL_W-1:0]        out_cell_value,
  input  wire logic                cfg_valid,
  output logic                     cfg_ready,
  input  wire logic [ATTR_W-1:0]   cfg_data
);

  localparam int CELLS = COLS * ROWS;
  localparam int AW    = $clog2(CELLS);

  logic [ATTR_W-1:0] text_attr_r;
  logic              out_valid_r;
  res_t              out_r;

  res_t              res;
  logic              res_valid;
  logic              res_ready;

  logic              wr_en;
  logic [AW-1:0]     wr_addr;
  logic [CELL_W-1:0] wr_data;
  logic              rd_en;
  logic [AW-1:0]     rd_addr;
  logic [CELL_W-1:0] rd_data;

  assign cfg_ready = 1'b1;
  assign res_ready = !out_valid_r || out_ready;

  assign out_valid      = out_valid_r;
  assign out_cursor_col = out_r.cursor_col;
  assign out_cursor_row = out_r.cursor_row;
  assign out_scrolled   = out_r.scrolled;
  assign out_cell_value = out_r.cell_value;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      text_attr_r <= RESET_ATTR;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid) begin
        text_attr_r <= cfg_data;
      end
      if (res_valid && res_ready) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
    if (res_valid && res_ready) begin
      out_r <= res;
    end
  end

  tcw_seq #(
    .COLS (COLS),
    .ROWS (ROWS)
  ) u_seq (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_action     (in_action),
    .in_char_code  (in_char_code),
    .in_attr       (in_attr),
    .in_cell_index (in_cell_index),
    .text_attr     (text_attr_r),
    .res_valid     (res_valid),
    .res_ready     (res_ready),
    .res           (res),
    .wr_en         (wr_en),
    .wr_addr       (wr_addr),
    .wr_data       (wr_data),
    .rd_en         (rd_en),
    .rd_addr       (rd_addr),
    .rd_data       (rd_data)
  );

  tcw_ram #(
    .WIDTH (CELL_W),
    .DEPTH (CELLS)
  ) u_screen (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

endmodule

`default_nettype wire

@@ rtl/tcw_ram.sv @@
// tcw_ram: generic single-clock ram, one write port and one registered read port
// no dependencies
`default_nettype none

module tcw_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2000,
  localparam int AW   = $clog2(DEPTH)
) (
  input  wire logic             clk,
  input  wire logic             wr_en,
  input  wire logic [AW-1:0]    wr_addr,
  input  wire logic [WIDTH-1:0] wr_data,
  input  wire logic             rd_en,
  input  wire logic [AW-1:0]    rd_addr,
  output logic      [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

@@ rtl/tcw_seq.sv @@
// tcw_seq: cursor state and sequencer for the screen ram (puts, scroll copy,
// fills, reads); uses tcw_pkg, drives the ports of one tcw_ram
`default_nettype none

module tcw_seq import tcw_pkg::*; #(
  parameter int COLS  = DEF_COLS,
  parameter int ROWS  = DEF_ROWS,
  localparam int CELLS = COLS * ROWS,
  localparam int AW    = $clog2(CELLS)
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire logic [ACTION_W-1:0] in_action,
  input  wire logic [CHAR_W-1:0]   in_char_code,
  input  wire logic [ATTR_W-1:0]   in_attr,
  input  wire logic [INDEX_W-1:0]  in_cell_index,
  input  wire logic [ATTR_W-1:0]   text_attr,
  output logic                     res_valid,
  input  wire logic                res_ready,
  output res_t                     res,
  output logic                     wr_en,
  output logic [AW-1:0]            wr_addr,
  output logic [CELL_W-1:0]        wr_data,
  output logic                     rd_en,
  output logic [AW-1:0]            rd_addr,
  input  wire logic [CELL_W-1:0]   rd_data
);

  localparam int CW  = $clog2(CELLS + 1);
  localparam int CLW = $clog2(COLS);
  localparam int RW  = $clog2(ROWS);

  typedef enum logic [2:0] {
    S_INIT,
    S_IDLE,
    S_READ,
    S_COPY,
    S_FILL,
    S_DONE
  } state_t;

  state_t            state_r, state_nxt;
  logic [CLW-1:0]    col_r, col_nxt;
  logic [RW-1:0]     row_r, row_nxt;
  logic [CW-1:0]     src_r, src_nxt;
  logic [AW-1:0]     dst_r, dst_nxt;
  logic              pend_r, pend_nxt;
  logic [CELL_W-1:0] fill_r, fill_nxt;
  logic              scr_r, scr_nxt;
  logic [CELL_W-1:0] val_r, val_nxt;

  logic [AW-1:0]     cur_addr;
  logic [ATTR_W-1:0] put_attr;
  logic              last_row;
  logic              last_col;
  logic              go_scroll;

  assign cur_addr = AW'(row_r) * AW'(COLS) + AW'(col_r);
  assign put_attr = (action_t'(in_action) == ACT_PUT_ATTR) ? in_attr : text_attr;
  assign last_row = (row_r == RW'(ROWS - 1));
  assign last_col = (col_r == CLW'(COLS - 1));

  assign res.cursor_col = OCOL_W'(col_r);
  assign res.cursor_row = OROW_W'(row_r);
  assign res.scrolled   = scr_r;
  assign res.cell_value = val_r;

  always_comb begin
    state_nxt = state_r;
    col_nxt   = col_r;
    row_nxt   = row_r;
    src_nxt   = src_r;
    dst_nxt   = dst_r;
    pend_nxt  = pend_r;
    fill_nxt  = fill_r;
    scr_nxt   = scr_r;
    val_nxt   = val_r;
    in_ready  = 1'b0;
    res_valid = 1'b0;
    wr_en     = 1'b0;
    wr_addr   = cur_addr;
    wr_data   = fill_r;
    rd_en     = 1'b0;
    rd_addr   = src_r[AW-1:0];
    go_scroll = 1'b0;

    case (state_r)
      S_INIT: begin
        wr_en   = 1'b1;
        wr_addr = dst_r;
        wr_data = make_cell(CHAR_BLANK, RESET_ATTR);
        dst_nxt = dst_r + AW'(1);
        if (dst_r == AW'(CELLS - 1)) begin
          state_nxt = S_IDLE;
        end
      end

      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          scr_nxt   = 1'b0;
          val_nxt   = '0;
          fill_nxt  = make_cell(CHAR_BLANK, put_attr);
          state_nxt = S_DONE;
          case (action_t'(in_action))
            ACT_PUT, ACT_PUT_ATTR: begin
              if (in_char_code == CHAR_NL) begin
                col_nxt = '0;
                if (last_row) begin
                  go_scroll = 1'b1;
                end else begin
                  row_nxt = row_r + RW'(1);
                end
              end else if (action_t'(in_action) == ACT_PUT && in_char_code == CHAR_BS) begin
                // backspace at column 0 leaves everything alone
                if (col_r != '0) begin
                  col_nxt = col_r - CLW'(1);
                  wr_en   = 1'b1;
                  wr_addr = cur_addr - AW'(1);
                  wr_data = make_cell(CHAR_BLANK, put_attr);
                end
              end else begin
                wr_en   = 1'b1;
                wr_data = make_cell(in_char_code, put_attr);
                if (last_col) begin
                  col_nxt = '0;
                  if (last_row) begin
                    go_scroll = 1'b1;
                  end else begin
                    row_nxt = row_r + RW'(1);
                  end
                end else begin
                  col_nxt = col_r + CLW'(1);
                end
              end
              if (go_scroll) begin
                scr_nxt   = 1'b1;
                src_nxt   = CW'(COLS);
                dst_nxt   = '0;
                pend_nxt  = 1'b0;
                state_nxt = S_COPY;
              end
            end
            ACT_CLEAR: begin
              col_nxt   = '0;
              row_nxt   = '0;
              dst_nxt   = '0;
              fill_nxt  = make_cell(CHAR_BLANK, text_attr);
              state_nxt = S_FILL;
            end
            ACT_READ: begin
              if (in_cell_index < CELLS) begin
                rd_en     = 1'b1;
                rd_addr   = AW'(in_cell_index);
                state_nxt = S_READ;
              end
            end
            default: begin
              state_nxt = S_DONE;
            end
          endcase
        end
      end

      S_READ: begin
        val_nxt   = rd_data;
        state_nxt = S_DONE;
      end

      S_COPY: begin
        // read one row ahead, write the cell read in the previous cycle
        if (src_r != CW'(CELLS)) begin
          rd_en    = 1'b1;
          src_nxt  = src_r + CW'(1);
          pend_nxt = 1'b1;
        end else begin
          pend_nxt = 1'b0;
        end
        if (pend_r) begin
          wr_en   = 1'b1;
          wr_addr = dst_r;
          wr_data = rd_data;
          dst_nxt = dst_r + AW'(1);
        end
        if (src_r == CW'(CELLS) && !pend_r) begin
          state_nxt = S_FILL;
        end
      end

      S_FILL: begin
        wr_en   = 1'b1;
        wr_addr = dst_r;
        wr_data = fill_r;
        if (dst_r == AW'(CELLS - 1)) begin
          state_nxt = S_DONE;
        end else begin
          dst_nxt = dst_r + AW'(1);
        end
      end

      S_DONE: begin
        res_valid = 1'b1;
        if (res_ready) begin
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_INIT;
      col_r   <= '0;
      row_r   <= '0;
      dst_r   <= '0;
      pend_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      col_r   <= col_nxt;
      row_r   <= row_nxt;
      dst_r   <= dst_nxt;
      pend_r  <= pend_nxt;
    end
    src_r  <= src_nxt;
    fill_r <= fill_nxt;
    scr_r  <= scr_nxt;
    val_r  <= val_nxt;
  end

endmodule

`default_nettype wire
